### src/tlsf_pkg.sv
// ----------------------------------------------------------------------------
// tlsf_pkg
// shared constants, types and class-index helpers of the segregated-fit
// allocator core
// ----------------------------------------------------------------------------
`default_nettype none

package tlsf_pkg;

  localparam int unsigned MAX_POOL_BYTES = 65536;
  localparam int unsigned FLI_COUNT      = 32;
  localparam int unsigned SLI_COUNT      = 16;
  localparam int unsigned HEADER_BYTES   = 40;
  localparam int unsigned MIN_BLOCK_BYTES = 64;
  localparam int unsigned ALIGN_BYTES    = 16;

  localparam int unsigned POOL_W  = 17;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned ALIGN_SH = $clog2(ALIGN_BYTES);
  localparam int unsigned SLOTS   = MAX_POOL_BYTES / ALIGN_BYTES + 1;
  localparam int unsigned IDX_W   = $clog2(SLOTS);
  localparam int unsigned FL_W    = $clog2(FLI_COUNT);
  localparam int unsigned SL_W    = $clog2(SLI_COUNT);
  localparam int unsigned CLASSES = FLI_COUNT * SLI_COUNT;
  localparam int unsigned CLASS_W = FL_W + SL_W;
  localparam int unsigned BLK_W   = POOL_W + 1;

  localparam logic [IDX_W-1:0] NONE_IDX = '1;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLEAR, ST_INIT,
    ST_A_OWN, ST_A_HEAD, ST_A_WALK, ST_A_UP, ST_A_UPHEAD, ST_A_UPCHK,
    ST_A_SPLIT0, ST_A_SPLIT1, ST_A_SPLIT2,
    ST_F_CHK, ST_F_NX, ST_F_NXM0, ST_F_NXM1, ST_F_NXM2,
    ST_F_PV0, ST_F_PV1, ST_F_PVM, ST_F_FIN,
    ST_Q_HEAD, ST_Q_WALK,
    ST_RM0, ST_RM1, ST_IN0, ST_IN1, ST_IN2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [FL_W-1:0] f;
    logic [SL_W-1:0] s;
  } cls_t;

  function automatic logic [FL_W-1:0] hibit_pool(input logic [POOL_W-1:0] x);
    logic [FL_W-1:0] r;
    r = '0;
    for (int i = 0; i < POOL_W; i++) begin
      if (x[i]) r = FL_W'(i);
    end
    return r;
  endfunction

  function automatic logic [FL_W-1:0] hibit_fl(input logic [FLI_COUNT-1:0] x);
    logic [FL_W-1:0] r;
    r = '0;
    for (int i = 0; i < FLI_COUNT; i++) begin
      if (x[i]) r = FL_W'(i);
    end
    return r;
  endfunction

  function automatic logic [FL_W-1:0] lobit_fl(input logic [FLI_COUNT-1:0] x);
    logic [FL_W-1:0] r;
    r = '0;
    for (int i = FLI_COUNT - 1; i >= 0; i--) begin
      if (x[i]) r = FL_W'(i);
    end
    return r;
  endfunction

  function automatic logic [SL_W-1:0] hibit_sl(input logic [SLI_COUNT-1:0] x);
    logic [SL_W-1:0] r;
    r = '0;
    for (int i = 0; i < SLI_COUNT; i++) begin
      if (x[i]) r = SL_W'(i);
    end
    return r;
  endfunction

  function automatic logic [SL_W-1:0] lobit_sl(input logic [SLI_COUNT-1:0] x);
    logic [SL_W-1:0] r;
    r = '0;
    for (int i = SLI_COUNT - 1; i >= 0; i--) begin
      if (x[i]) r = SL_W'(i);
    end
    return r;
  endfunction

  // bits strictly above position s
  function automatic logic [SLI_COUNT-1:0] above_sl(input logic [SL_W-1:0] s);
    logic [SLI_COUNT:0] m;
    m = ({(SLI_COUNT+1){1'b1}} << s) << 1;
    return m[SLI_COUNT-1:0];
  endfunction

  function automatic logic [FLI_COUNT-1:0] above_fl(input logic [FL_W-1:0] f);
    logic [FLI_COUNT:0] m;
    m = ({(FLI_COUNT+1){1'b1}} << f) << 1;
    return m[FLI_COUNT-1:0];
  endfunction

  // first level is log2, second level splits each power-of-two range linearly
  function automatic cls_t size_class(input logic [POOL_W-1:0] size);
    cls_t c;
    logic [FL_W-1:0] f;
    logic [POOL_W-1:0] rem;
    logic [POOL_W-1:0] q;
    f = hibit_pool(size);
    rem = size - (POOL_W'(1) << f);
    if (f >= FL_W'(SL_W)) q = rem >> (f - FL_W'(SL_W));
    else q = rem;
    c.f = f;
    c.s = (size == '0) ? '0 : q[SL_W-1:0];
    return c;
  endfunction

endpackage

`default_nettype wire

### src/two_level_segregated_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// two_level_segregated_fit_allocator_core
// segregated-fit allocator over a pool of byte offsets, one request at a time
// ----------------------------------------------------------------------------
// Usage: pulse start with in_kind and the operands while busy is low; the word
// is taken at that edge and busy stays high until the answer is out. The
// answer (out_ok, out_addr, out_max_avail) is shown for exactly one cycle with
// out_valid high; the receiver cannot stall it, and the next request may be
// issued in that same cycle.
// Steps: an allocate first walks the blocks of its own size class, then, when
// none fits there, takes the head of the next larger non-empty class; a block
// that leaves enough remainder is split and the rest goes back on a free list.
// A zero or oversize request is answered without a search. A free merges with
// the free blocks physically next to and before it, and a null or rejected free
// is answered without a search. A query walks the list of the highest non-empty
// class. The block-table memories give one registered read and one write per
// cycle each, walked by one sequencer.
// Reset and every cfg_we write start a clearing pass over all 4097 entries of
// the block table, then set up the pool as one free block (none for an empty
// pool); busy is high throughout. cfg_wdata is the pool size in bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_segregated_fit_allocator_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [tlsf_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [tlsf_pkg::POOL_W-1:0]   in_req_size,
  input  wire logic [tlsf_pkg::ADDR_W-1:0]   in_release_addr,
  input  wire logic                          in_release_valid,
  output logic                               out_valid,
  output logic                               out_ok,
  output logic      [tlsf_pkg::ADDR_W-1:0]   out_addr,
  output logic      [tlsf_pkg::POOL_W-1:0]   out_max_avail,
  input  wire logic                          cfg_we,
  input  wire logic [tlsf_pkg::POOL_W-1:0]   cfg_wdata
);

  import tlsf_pkg::*;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [POOL_W-1:0] pool_r, pool_nxt;
  logic [SLI_COUNT-1:0] slm_r [FLI_COUNT];
  logic [SLI_COUNT-1:0] slm_nxt [FLI_COUNT];
  logic [FLI_COUNT-1:0] fl_map;

  logic [POOL_W-1:0] size_r, size_nxt, bb_r, bb_nxt, xb_r, xb_nxt, best_r, best_nxt;
  logic [IDX_W-1:0]  b_r, b_nxt, x_r, x_nxt, h_r, h_nxt, nx_r, nx_nxt;
  logic [IDX_W-1:0]  pv_r, pv_nxt, nn_r, nn_nxt;
  logic              ok_r, ok_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [POOL_W-1:0] avail_r, avail_nxt;
  logic              out_valid_r, out_valid_nxt, out_ok_r, out_ok_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [POOL_W-1:0] out_avail_r, out_avail_nxt;

  // memory ports
  logic              blk_we, pp_we, pn_we, lp_we, ln_we, ch_we;
  logic [IDX_W-1:0]  blk_waddr, blk_raddr, pp_waddr, pp_raddr, pn_waddr, pn_raddr;
  logic [IDX_W-1:0]  lp_waddr, lp_raddr, ln_waddr, ln_raddr;
  logic [CLASS_W-1:0] ch_waddr, ch_raddr;
  logic [BLK_W-1:0]  blk_wdata, blk_rdata;
  logic [IDX_W-1:0]  pp_wdata, pp_rdata, pn_wdata, pn_rdata;
  logic [IDX_W-1:0]  lp_wdata, lp_rdata, ln_wdata, ln_rdata, ch_wdata, ch_rdata;

  // shared class unit
  logic [POOL_W-1:0] cls_src;
  cls_t              cls;

  // scratch
  logic [POOL_W:0]   sz_wide;
  logic [POOL_W-1:0] sz, rem, p_init, bsum;
  logic [ADDR_W-1:0] off;
  logic [SLI_COUNT-1:0] sl_up;
  logic [FLI_COUNT-1:0] fl_up;
  logic [FL_W-1:0]   f2;
  cls_t              qc;

  tlsf_ram #(.WIDTH(BLK_W), .DEPTH(SLOTS)) u_blk (
    .clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
    .raddr(blk_raddr), .rdata(blk_rdata));
  tlsf_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_phys_prev (
    .clk(clk), .we(pp_we), .waddr(pp_waddr), .wdata(pp_wdata),
    .raddr(pp_raddr), .rdata(pp_rdata));
  tlsf_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_phys_next (
    .clk(clk), .we(pn_we), .waddr(pn_waddr), .wdata(pn_wdata),
    .raddr(pn_raddr), .rdata(pn_rdata));
  tlsf_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_list_prev (
    .clk(clk), .we(lp_we), .waddr(lp_waddr), .wdata(lp_wdata),
    .raddr(lp_raddr), .rdata(lp_rdata));
  tlsf_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_list_next (
    .clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
    .raddr(ln_raddr), .rdata(ln_rdata));
  tlsf_ram #(.WIDTH(IDX_W), .DEPTH(CLASSES)) u_class_head (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata));

  always_comb begin
    for (int i = 0; i < FLI_COUNT; i++) fl_map[i] = |slm_r[i];
  end

  assign cls_src = (state_r == ST_A_OWN || state_r == ST_A_UP) ? size_r : xb_r;
  assign cls     = size_class(cls_src);
  assign busy    = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cnt_nxt   = cnt_r;
    pool_nxt  = pool_r;
    for (int i = 0; i < FLI_COUNT; i++) slm_nxt[i] = slm_r[i];
    size_nxt  = size_r;
    bb_nxt    = bb_r;
    xb_nxt    = xb_r;
    best_nxt  = best_r;
    b_nxt     = b_r;
    x_nxt     = x_r;
    h_nxt     = h_r;
    nx_nxt    = nx_r;
    pv_nxt    = pv_r;
    nn_nxt    = nn_r;
    ok_nxt    = ok_r;
    addr_nxt  = addr_r;
    avail_nxt = avail_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = out_ok_r;
    out_addr_nxt  = out_addr_r;
    out_avail_nxt = out_avail_r;

    blk_we = 1'b0; blk_waddr = '0; blk_wdata = '0; blk_raddr = '0;
    pp_we  = 1'b0; pp_waddr  = '0; pp_wdata  = '0; pp_raddr  = '0;
    pn_we  = 1'b0; pn_waddr  = '0; pn_wdata  = '0; pn_raddr  = '0;
    lp_we  = 1'b0; lp_waddr  = '0; lp_wdata  = '0; lp_raddr  = '0;
    ln_we  = 1'b0; ln_waddr  = '0; ln_wdata  = '0; ln_raddr  = '0;
    ch_we  = 1'b0; ch_waddr  = '0; ch_wdata  = '0; ch_raddr  = '0;

    sz_wide = {1'b0, in_req_size} + (POOL_W+1)'(ALIGN_BYTES - 1);
    sz_wide[ALIGN_SH-1:0] = '0;
    sz      = (sz_wide < (POOL_W+1)'(MIN_BLOCK_BYTES)) ? POOL_W'(MIN_BLOCK_BYTES)
                                                      : sz_wide[POOL_W-1:0];
    off     = in_release_addr - ADDR_W'(HEADER_BYTES);
    rem     = bb_r - size_r;
    p_init  = (pool_r > POOL_W'(MAX_POOL_BYTES)) ? POOL_W'(MAX_POOL_BYTES) : pool_r;
    p_init[ALIGN_SH-1:0] = '0;
    bsum    = xb_r + bb_r;
    sl_up   = slm_r[cls.f] & above_sl(cls.s);
    fl_up   = fl_map & above_fl(cls.f);
    f2      = lobit_fl(fl_up);
    qc.f    = hibit_fl(fl_map);
    qc.s    = hibit_sl(slm_r[qc.f]);

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ok_nxt    = 1'b0;
          addr_nxt  = '0;
          avail_nxt = '0;
          case (in_kind)
            KIND_ALLOC: begin
              if (in_req_size == '0 || sz_wide > (POOL_W+1)'(MAX_POOL_BYTES)) begin
                state_nxt = ST_DONE;
              end else begin
                size_nxt  = sz;
                state_nxt = ST_A_OWN;
              end
            end
            KIND_FREE: begin
              if (!in_release_valid) begin
                ok_nxt    = 1'b1;
                state_nxt = ST_DONE;
              end else if (in_release_addr < ADDR_W'(HEADER_BYTES) ||
                           off[ALIGN_SH-1:0] != '0) begin
                state_nxt = ST_DONE;
              end else begin
                b_nxt     = IDX_W'(off >> ALIGN_SH);
                blk_raddr = b_nxt;
                pn_raddr  = b_nxt;
                pp_raddr  = b_nxt;
                state_nxt = ST_F_CHK;
              end
            end
            KIND_QUERY: begin
              ok_nxt   = 1'b1;
              best_nxt = '0;
              if (fl_map == '0) begin
                state_nxt = ST_DONE;
              end else begin
                ch_raddr  = qc;
                state_nxt = ST_Q_HEAD;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      ST_CLEAR: begin
        blk_we    = 1'b1;
        blk_waddr = cnt_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(SLOTS - 1)) state_nxt = ST_INIT;
      end

      ST_INIT: begin
        if (p_init != '0) begin
          blk_we = 1'b1; blk_waddr = '0; blk_wdata = {1'b1, p_init};
          pp_we  = 1'b1; pp_waddr  = '0; pp_wdata  = NONE_IDX;
          pn_we  = 1'b1; pn_waddr  = '0; pn_wdata  = NONE_IDX;
          x_nxt     = '0;
          xb_nxt    = p_init;
          ret_nxt   = ST_IDLE;
          state_nxt = ST_IN0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      // search the request's own class for a block that really fits
      ST_A_OWN: begin
        if (slm_r[cls.f][cls.s]) begin
          ch_raddr  = cls;
          state_nxt = ST_A_HEAD;
        end else begin
          state_nxt = ST_A_UP;
        end
      end

      ST_A_HEAD: begin
        b_nxt     = ch_rdata;
        blk_raddr = ch_rdata;
        ln_raddr  = ch_rdata;
        state_nxt = ST_A_WALK;
      end

      ST_A_WALK: begin
        if (blk_rdata[POOL_W-1:0] >= size_r) begin
          bb_nxt    = blk_rdata[POOL_W-1:0];
          x_nxt     = b_r;
          xb_nxt    = blk_rdata[POOL_W-1:0];
          ret_nxt   = ST_A_SPLIT0;
          state_nxt = ST_RM0;
        end else if (ln_rdata == NONE_IDX) begin
          state_nxt = ST_A_UP;
        end else begin
          b_nxt     = ln_rdata;
          blk_raddr = ln_rdata;
          ln_raddr  = ln_rdata;
        end
      end

      ST_A_UP: begin
        if (sl_up != '0) begin
          ch_raddr  = {cls.f, lobit_sl(sl_up)};
          state_nxt = ST_A_UPHEAD;
        end else if (fl_up != '0) begin
          ch_raddr  = {f2, lobit_sl(slm_r[f2])};
          state_nxt = ST_A_UPHEAD;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_A_UPHEAD: begin
        b_nxt     = ch_rdata;
        blk_raddr = ch_rdata;
        state_nxt = ST_A_UPCHK;
      end

      ST_A_UPCHK: begin
        if (blk_rdata[POOL_W-1:0] >= size_r) begin
          bb_nxt    = blk_rdata[POOL_W-1:0];
          x_nxt     = b_r;
          xb_nxt    = blk_rdata[POOL_W-1:0];
          ret_nxt   = ST_A_SPLIT0;
          state_nxt = ST_RM0;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_A_SPLIT0: begin
        ok_nxt   = 1'b1;
        addr_nxt = {b_r[IDX_W-2:0], {ALIGN_SH{1'b0}}} + ADDR_W'(HEADER_BYTES);
        if (rem >= POOL_W'(MIN_BLOCK_BYTES)) begin
          pn_raddr  = b_r;
          state_nxt = ST_A_SPLIT1;
        end else begin
          blk_we = 1'b1; blk_waddr = b_r; blk_wdata = {1'b0, bb_r};
          state_nxt = ST_DONE;
        end
      end

      ST_A_SPLIT1: begin
        x_nxt  = b_r + size_r[POOL_W-1:ALIGN_SH];
        nn_nxt = pn_rdata;
        blk_we = 1'b1; blk_waddr = x_nxt; blk_wdata = {1'b1, rem};
        pp_we  = 1'b1; pp_waddr  = x_nxt; pp_wdata  = b_r;
        pn_we  = 1'b1; pn_waddr  = x_nxt; pn_wdata  = pn_rdata;
        state_nxt = ST_A_SPLIT2;
      end

      ST_A_SPLIT2: begin
        pp_we = (nn_r != NONE_IDX); pp_waddr = nn_r; pp_wdata = x_r;
        pn_we = 1'b1; pn_waddr = b_r; pn_wdata = x_r;
        blk_we = 1'b1; blk_waddr = b_r; blk_wdata = {1'b0, size_r};
        xb_nxt    = rem;
        ret_nxt   = ST_DONE;
        state_nxt = ST_IN0;
      end

      ST_F_CHK: begin
        if (blk_rdata[POOL_W-1:0] == '0 || blk_rdata[POOL_W]) begin
          state_nxt = ST_DONE;
        end else begin
          bb_nxt = blk_rdata[POOL_W-1:0];
          nx_nxt = pn_rdata;
          nn_nxt = pn_rdata;
          pv_nxt = pp_rdata;
          if (pn_rdata != NONE_IDX) begin
            blk_raddr = pn_rdata;
            state_nxt = ST_F_NX;
          end else begin
            state_nxt = ST_F_PV0;
          end
        end
      end

      ST_F_NX: begin
        if (blk_rdata[POOL_W]) begin
          x_nxt     = nx_r;
          xb_nxt    = blk_rdata[POOL_W-1:0];
          bb_nxt    = bb_r + blk_rdata[POOL_W-1:0];
          ret_nxt   = ST_F_NXM0;
          state_nxt = ST_RM0;
        end else begin
          state_nxt = ST_F_PV0;
        end
      end

      ST_F_NXM0: begin
        pn_raddr  = nx_r;
        state_nxt = ST_F_NXM1;
      end

      ST_F_NXM1: begin
        nn_nxt = pn_rdata;
        pn_we  = 1'b1; pn_waddr = b_r; pn_wdata = pn_rdata;
        blk_we = 1'b1; blk_waddr = nx_r; blk_wdata = '0;
        state_nxt = ST_F_NXM2;
      end

      ST_F_NXM2: begin
        pp_we = (nn_r != NONE_IDX); pp_waddr = nn_r; pp_wdata = b_r;
        state_nxt = ST_F_PV0;
      end

      ST_F_PV0: begin
        if (pv_r != NONE_IDX) begin
          blk_raddr = pv_r;
          state_nxt = ST_F_PV1;
        end else begin
          state_nxt = ST_F_FIN;
        end
      end

      ST_F_PV1: begin
        if (blk_rdata[POOL_W]) begin
          x_nxt     = pv_r;
          xb_nxt    = blk_rdata[POOL_W-1:0];
          ret_nxt   = ST_F_PVM;
          state_nxt = ST_RM0;
        end else begin
          state_nxt = ST_F_FIN;
        end
      end

      // absorb into the free block physically before
      ST_F_PVM: begin
        bb_nxt = bsum;
        pn_we  = 1'b1; pn_waddr = pv_r; pn_wdata = nn_r;
        pp_we  = (nn_r != NONE_IDX); pp_waddr = nn_r; pp_wdata = pv_r;
        blk_we = 1'b1; blk_waddr = b_r; blk_wdata = '0;
        b_nxt     = pv_r;
        state_nxt = ST_F_FIN;
      end

      ST_F_FIN: begin
        blk_we = 1'b1; blk_waddr = b_r; blk_wdata = {1'b1, bb_r};
        x_nxt     = b_r;
        xb_nxt    = bb_r;
        ok_nxt    = 1'b1;
        ret_nxt   = ST_DONE;
        state_nxt = ST_IN0;
      end

      ST_Q_HEAD: begin
        blk_raddr = ch_rdata;
        ln_raddr  = ch_rdata;
        state_nxt = ST_Q_WALK;
      end

      ST_Q_WALK: begin
        if (blk_rdata[POOL_W-1:0] > best_r) best_nxt = blk_rdata[POOL_W-1:0];
        if (ln_rdata == NONE_IDX) begin
          avail_nxt = (best_nxt > POOL_W'(HEADER_BYTES)) ?
                      best_nxt - POOL_W'(HEADER_BYTES) : '0;
          state_nxt = ST_DONE;
        end else begin
          blk_raddr = ln_rdata;
          ln_raddr  = ln_rdata;
        end
      end

      // unlink x from its class list
      ST_RM0: begin
        lp_raddr  = x_r;
        ln_raddr  = x_r;
        state_nxt = ST_RM1;
      end

      ST_RM1: begin
        if (lp_rdata != NONE_IDX) begin
          ln_we = 1'b1; ln_waddr = lp_rdata; ln_wdata = ln_rdata;
        end else begin
          ch_we = 1'b1; ch_waddr = cls; ch_wdata = ln_rdata;
        end
        lp_we = (ln_rdata != NONE_IDX); lp_waddr = ln_rdata; lp_wdata = lp_rdata;
        if (lp_rdata == NONE_IDX && ln_rdata == NONE_IDX) slm_nxt[cls.f][cls.s] = 1'b0;
        state_nxt = ret_r;
      end

      // push x at the head of its class list
      ST_IN0: begin
        ch_raddr  = cls;
        state_nxt = ST_IN1;
      end

      ST_IN1: begin
        h_nxt = slm_r[cls.f][cls.s] ? ch_rdata : NONE_IDX;
        ln_we = 1'b1; ln_waddr = x_r; ln_wdata = h_nxt;
        lp_we = 1'b1; lp_waddr = x_r; lp_wdata = NONE_IDX;
        ch_we = 1'b1; ch_waddr = cls; ch_wdata = x_r;
        slm_nxt[cls.f][cls.s] = 1'b1;
        state_nxt = ST_IN2;
      end

      ST_IN2: begin
        lp_we = (h_r != NONE_IDX); lp_waddr = h_r; lp_wdata = x_r;
        state_nxt = ret_r;
      end

      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_ok_nxt    = ok_r;
        out_addr_nxt  = addr_r;
        out_avail_nxt = avail_r;
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase

    // a pool write rebuilds everything
    if (cfg_we) begin
      pool_nxt  = cfg_wdata;
      cnt_nxt   = '0;
      state_nxt = ST_CLEAR;
      for (int i = 0; i < FLI_COUNT; i++) slm_nxt[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ret_r       <= ST_IDLE;
      cnt_r       <= '0;
      pool_r      <= POOL_W'(MAX_POOL_BYTES);
      out_valid_r <= 1'b0;
      for (int i = 0; i < FLI_COUNT; i++) slm_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      pool_r      <= pool_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < FLI_COUNT; i++) slm_r[i] <= slm_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    bb_r    <= bb_nxt;
    xb_r    <= xb_nxt;
    best_r  <= best_nxt;
    b_r     <= b_nxt;
    x_r     <= x_nxt;
    h_r     <= h_nxt;
    nx_r    <= nx_nxt;
    pv_r    <= pv_nxt;
    nn_r    <= nn_nxt;
    ok_r    <= ok_nxt;
    addr_r  <= addr_nxt;
    avail_r <= avail_nxt;
    out_ok_r    <= out_ok_nxt;
    out_addr_r  <= out_addr_nxt;
    out_avail_r <= out_avail_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_addr      = out_addr_r;
  assign out_max_avail = out_avail_r;

  // a word leaves only from the finishing step, never twice in a row
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_DONE))
    else $error("result strobe without finishing step");

  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (fl_map == '0))
    else $error("class bitmap not empty during clearing pass");

endmodule

`default_nettype wire

### src/tlsf_ram.sv
// ----------------------------------------------------------------------------
// tlsf_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tlsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
